/* design/weighted_centroid_macros.svh */
// ----------------------------------------------------------------------------
// weighted centroid assertion macros
// shorthand for the concurrent checks used by the centroid checker
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_CENTROID_MACROS_SVH
`define WEIGHTED_CENTROID_MACROS_SVH

// same-cycle implication, off while reset is high
`define WC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("weighted centroid check failed");

// next-cycle implication, also checked across reset
`define WC_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("weighted centroid check failed");

`endif

/* design/wc_pkg.sv */
// ----------------------------------------------------------------------------
// weighted centroid package
// shared widths, register codes and the frame sum record
// ----------------------------------------------------------------------------
package wc_pkg;

   localparam int MAX_DIM       = 256;
   localparam int DIM_BITS      = $clog2(MAX_DIM + 1);
   localparam int POS_BITS      = $clog2(MAX_DIM);
   localparam int WEIGHT_BITS   = 16;
   localparam int MOMENT_BITS   = 48;
   localparam int WSUM_BITS     = 32;
   localparam int QUOT_BITS     = DIM_BITS;
   localparam int STEP_BITS     = $clog2(QUOT_BITS);
   localparam int CSR_DATA_BITS = 9;
   localparam int CSR_IDX_BITS  = 1;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_DATA_BITS-1:0] ROWS_RESET = CSR_DATA_BITS'(2);
   localparam logic [CSR_DATA_BITS-1:0] COLS_RESET = CSR_DATA_BITS'(2);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ROWS_IN_USE = 1'b0,
      REG_COLS_IN_USE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [MOMENT_BITS-1:0] row_moment_sum;
      logic [MOMENT_BITS-1:0] col_moment_sum;
      logic [WSUM_BITS-1:0]   weight_sum;
   } frame_sums_type;

   // size register to the dimension actually used: zero counts as one, saturate high
   function automatic logic [DIM_BITS-1:0] effective_dim(input logic [CSR_DATA_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = DIM_BITS'(v);
      end
      return r;
   endfunction

endpackage

/* design/wc_if.sv */
// ----------------------------------------------------------------------------
// weighted centroid channels
// valid/ready stream interfaces for weight beats and centroid beats
// ----------------------------------------------------------------------------
interface wc_req_if;
   import wc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [WEIGHT_BITS-1:0] weight;

   modport source (output valid, output weight, input ready);
   modport sink   (input valid, input weight, output ready);
endinterface

interface wc_rsp_if;
   import wc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [QUOT_BITS-1:0] centroid_row;
   logic [QUOT_BITS-1:0] centroid_col;
   logic                 empty_frame;

   modport source (output valid, output centroid_row, output centroid_col,
                   output empty_frame, input ready);
   modport sink   (input valid, input centroid_row, input centroid_col,
                   input empty_frame, output ready);
endinterface

/* design/wc_queue.sv */
// ----------------------------------------------------------------------------
// weighted centroid frame queue
// short fifo of finished frame sums between accumulator and divider
// ----------------------------------------------------------------------------
module wc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  wc_pkg::frame_sums_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output wc_pkg::frame_sums_type head_data
);
   import wc_pkg::*;

   frame_sums_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QCNT_BITS-1:0]   count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (32'(count_ff) == QUEUE_DEPTH);
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= QPTR_BITS'(32'(wr_ptr_ff) == QUEUE_DEPTH - 1 ? 0 : 32'(wr_ptr_ff) + 1);
         end
         if (do_pop) begin
            rd_ptr_ff <= QPTR_BITS'(32'(rd_ptr_ff) == QUEUE_DEPTH - 1 ? 0 : 32'(rd_ptr_ff) + 1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_BITS'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_BITS'(1);
         end
      end
   end

endmodule

/* design/wc_front.sv */
// ----------------------------------------------------------------------------
// weighted centroid accumulator
// raster position tracking, moment sums and size registers
// ----------------------------------------------------------------------------
module wc_front (
   input  logic                              clock,
   input  logic                              reset,
   wc_req_if.sink                            req_ch,
   input  logic                              csr_we,
   input  wc_pkg::csr_index_type             csr_index,
   input  logic [wc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                              push_valid,
   output wc_pkg::frame_sums_type            push_data,
   input  logic                              queue_full
);
   import wc_pkg::*;

   logic [CSR_DATA_BITS-1:0]        rows_cfg_ff;
   logic [CSR_DATA_BITS-1:0]        cols_cfg_ff;
   logic [POS_BITS-1:0]             row_pos_ff;
   logic [POS_BITS-1:0]             col_pos_ff;
   logic [MOMENT_BITS-1:0]          row_sum_ff;
   logic [MOMENT_BITS-1:0]          col_sum_ff;
   logic [WSUM_BITS-1:0]            wsum_ff;
   logic [MOMENT_BITS-1:0]          row_sum_in;
   logic [MOMENT_BITS-1:0]          col_sum_in;
   logic [WSUM_BITS-1:0]            wsum_in;
   logic [DIM_BITS-1:0]             rows_eff;
   logic [DIM_BITS-1:0]             cols_eff;
   logic [DIM_BITS-1:0]             row_idx;
   logic [DIM_BITS-1:0]             col_idx;
   logic [WEIGHT_BITS+DIM_BITS-1:0] row_prod;
   logic [WEIGHT_BITS+DIM_BITS-1:0] col_prod;
   logic                            last_col;
   logic                            last_row;
   logic                            accept;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      rows_eff   = effective_dim(rows_cfg_ff);
      cols_eff   = effective_dim(cols_cfg_ff);
      // 1-based position of this element
      row_idx    = DIM_BITS'(row_pos_ff) + DIM_BITS'(1);
      col_idx    = DIM_BITS'(col_pos_ff) + DIM_BITS'(1);
      last_col   = (col_idx >= cols_eff);
      last_row   = (row_idx >= rows_eff);
      row_prod   = (WEIGHT_BITS+DIM_BITS)'(req_ch.weight) * (WEIGHT_BITS+DIM_BITS)'(row_idx);
      col_prod   = (WEIGHT_BITS+DIM_BITS)'(req_ch.weight) * (WEIGHT_BITS+DIM_BITS)'(col_idx);
      row_sum_in = row_sum_ff + MOMENT_BITS'(row_prod);
      col_sum_in = col_sum_ff + MOMENT_BITS'(col_prod);
      wsum_in    = wsum_ff + WSUM_BITS'(req_ch.weight);
   end

   assign push_valid               = accept && last_col && last_row;
   assign push_data.row_moment_sum = row_sum_in;
   assign push_data.col_moment_sum = col_sum_in;
   assign push_data.weight_sum     = wsum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= ROWS_RESET;
         cols_cfg_ff <= COLS_RESET;
         row_pos_ff  <= '0;
         col_pos_ff  <= '0;
         row_sum_ff  <= '0;
         col_sum_ff  <= '0;
         wsum_ff     <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_ROWS_IN_USE: rows_cfg_ff <= csr_wdata;
               REG_COLS_IN_USE: cols_cfg_ff <= csr_wdata;
            endcase
         end
         if (accept) begin
            if (last_col && last_row) begin
               row_pos_ff <= '0;
               col_pos_ff <= '0;
               row_sum_ff <= '0;
               col_sum_ff <= '0;
               wsum_ff    <= '0;
            end else begin
               row_sum_ff <= row_sum_in;
               col_sum_ff <= col_sum_in;
               wsum_ff    <= wsum_in;
               if (last_col) begin
                  col_pos_ff <= '0;
                  row_pos_ff <= row_pos_ff + POS_BITS'(1);
               end else begin
                  col_pos_ff <= col_pos_ff + POS_BITS'(1);
               end
            end
         end
      end
   end

endmodule

/* design/wc_divider.sv */
// ----------------------------------------------------------------------------
// weighted centroid divider
// shared restoring divider, one quotient bit per cycle, row then column
// ----------------------------------------------------------------------------
module wc_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  wc_pkg::frame_sums_type head_data,
   output logic                   pop,
   wc_rsp_if.source               rsp_ch
);
   import wc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   logic                   col_phase_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic [MOMENT_BITS-1:0] rem_ff;
   logic [MOMENT_BITS-1:0] col_dividend_ff;
   logic [WSUM_BITS-1:0]   divisor_ff;
   logic [QUOT_BITS-1:0]   quot_ff;
   logic [QUOT_BITS-1:0]   row_quot_ff;
   logic                   empty_ff;
   logic                   rsp_valid_ff;
   logic [QUOT_BITS-1:0]   rsp_row_ff;
   logic [QUOT_BITS-1:0]   rsp_col_ff;
   logic                   rsp_empty_ff;
   logic [MOMENT_BITS-1:0] shifted_div;
   logic [MOMENT_BITS:0]   diff;
   logic                   fits;
   logic                   out_free;
   logic                   load_out;

   // quotient never exceeds MAX_DIM, so QUOT_BITS trial subtractions cover it
   assign shifted_div = MOMENT_BITS'(divisor_ff) << step_ff;
   assign diff        = {1'b0, rem_ff} - {1'b0, shifted_div};
   assign fits        = !diff[MOMENT_BITS];
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign load_out    = (state_ff == ST_FINISH) && out_free;
   assign pop         = (state_ff == ST_IDLE) && head_valid;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.centroid_row = rsp_row_ff;
   assign rsp_ch.centroid_col = rsp_col_ff;
   assign rsp_ch.empty_frame  = rsp_empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  rem_ff          <= head_data.row_moment_sum;
                  col_dividend_ff <= head_data.col_moment_sum;
                  divisor_ff      <= head_data.weight_sum;
                  col_phase_ff    <= 1'b0;
                  step_ff         <= STEP_BITS'(QUOT_BITS - 1);
                  quot_ff         <= '0;
                  if (head_data.weight_sum == '0) begin
                     row_quot_ff <= '0;
                     empty_ff    <= 1'b1;
                     state_ff    <= ST_FINISH;
                  end else begin
                     empty_ff    <= 1'b0;
                     state_ff    <= ST_DIVIDE;
                  end
               end
            end
            ST_DIVIDE: begin
               if (step_ff == '0 && !col_phase_ff) begin
                  // row quotient done, start on the column dividend
                  row_quot_ff  <= {quot_ff[QUOT_BITS-2:0], fits};
                  rem_ff       <= col_dividend_ff;
                  quot_ff      <= '0;
                  col_phase_ff <= 1'b1;
                  step_ff      <= STEP_BITS'(QUOT_BITS - 1);
               end else begin
                  if (fits) begin
                     rem_ff <= diff[MOMENT_BITS-1:0];
                  end
                  quot_ff <= {quot_ff[QUOT_BITS-2:0], fits};
                  if (step_ff == '0) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     step_ff <= step_ff - STEP_BITS'(1);
                  end
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_row_ff   <= row_quot_ff;
                  rsp_col_ff   <= quot_ff;
                  rsp_empty_ff <= empty_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* design/weighted_centroid.sv */
// ----------------------------------------------------------------------------
// weighted centroid
// streaming image-moment centroid of one weight frame in raster order
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  req_ch    in   valid/ready         weight[15:0]
//  rsp_ch    out  valid/ready         centroid_row[8:0], centroid_col[8:0], empty_frame
//  csr_*     in   csr_we, no stall    csr_index[0], csr_wdata[8:0]
//
//  weight beats are taken one per cycle by the accumulator while the queue has room
//  each weighted frame then walks idle, the row and column divide steps and finish
//  in the shared divider, an empty frame only idle and finish
//  frames shorter than that back up the two-entry sum queue and req_ch.ready drops
//  a stalled rsp_ch holds the divider in its final state, not the accumulator
//  synchronous reset restores both size registers to 2 and clears all sums, no sweep
// ----------------------------------------------------------------------------
module weighted_centroid (
   input  logic                              clock,
   input  logic                              reset,
   wc_req_if.sink                            req_ch,
   wc_rsp_if.source                          rsp_ch,
   input  logic                              csr_we,
   input  wc_pkg::csr_index_type             csr_index,
   input  logic [wc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import wc_pkg::*;

   // finished frame sums, accumulator side
   logic           push_valid;
   frame_sums_type push_data;
   logic           queue_full;

   // queue head, divider side
   logic           head_valid;
   frame_sums_type head_data;
   logic           pop;

   // position counters, moment sums and size registers
   wc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // decouples per-element accumulation from per-frame division
   wc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // two truncating quotients per frame plus output register
   wc_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

/* design/wc_checker.sv */
// ----------------------------------------------------------------------------
// weighted centroid checker
// port-level checks on centroid beats, bound to the top level
// ----------------------------------------------------------------------------
`include "weighted_centroid_macros.svh"

module wc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [wc_pkg::QUOT_BITS-1:0] rsp_row,
   input logic [wc_pkg::QUOT_BITS-1:0] rsp_col,
   input logic                        rsp_empty
);
   import wc_pkg::*;

   logic row_in_range;
   logic col_in_range;

   assign row_in_range = (32'(rsp_row) <= MAX_DIM);
   assign col_in_range = (32'(rsp_col) <= MAX_DIM);

   // nothing shows on the result side right after reset
   `WC_ASSERT_NEXT(a_idle_after_reset, clock, reset, !rsp_valid)

   // empty frame carries zero coordinates
   `WC_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && rsp_empty, rsp_row == '0 && rsp_col == '0)

   // weighted mean never exceeds MAX_DIM
   `WC_ASSERT_NOW(a_in_range, clock, reset, rsp_valid, row_in_range && col_in_range)

   // a stalled beat keeps its payload
   `WC_ASSERT_NOW(a_hold, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid && $stable(rsp_row) && $stable(rsp_col) && $stable(rsp_empty))

endmodule

bind weighted_centroid wc_checker u_wc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_row   (rsp_ch.centroid_row),
   .rsp_col   (rsp_ch.centroid_col),
   .rsp_empty (rsp_ch.empty_frame)
);
